/* rtl/fixed_step_tick_scheduler_macros.svh */
// assertion macros for the fixed-step tick scheduler
// taken in by the controller and datapath modules; no other dependencies
`ifndef FIXED_STEP_TICK_SCHEDULER_MACROS_SVH
`define FIXED_STEP_TICK_SCHEDULER_MACROS_SVH
`ifndef ASSERT_OFF
// plain property, disabled during reset
`define FSTS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// same-cycle implication
`define FSTS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define FSTS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define FSTS_ASSERT(lbl, clk, rst, prop, msg)
`define FSTS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define FSTS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

/* rtl/fsts_pkg.sv */
// shared widths, constants and control structs of the fixed-step tick scheduler
// no dependencies
package fsts_pkg;

   localparam int ELAPSED_W     = 20;
   localparam int STEP_W        = 17;
   localparam int TICK_ACCUM_W  = 24;
   localparam int COUNT_W       = 8;
   localparam int RATE_W        = 10;
   localparam int REQ_DATA_W    = 24;
   localparam int RSP_DATA_W    = 16;
   localparam int CSR_INDEX_W   = 1;

   localparam int MAX_CATCHUP_DEF    = 10;
   localparam int TIME_FRAC_BITS_DEF = 16;

   localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(2185);

   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_PERIOD = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE      = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic load;         // accepted elapsed time while enabled
      logic tick_take;    // tick result taken by the receiver
      logic status_take;  // status result taken by the receiver
      logic show_tick;    // response stage presents a tick result
   } cmd_type;

   // datapath to controller, from registers and the input data only
   typedef struct packed {
      logic enabled;
      logic tick_on_load;     // a tick is due once the offered elapsed time is added
      logic tick_after_take;  // another tick is due after the one being taken, within the catch-up limit
   } sts_type;

endpackage

/* rtl/fixed_step_tick_scheduler.sv */
// top level of the fixed-step tick scheduler
// depends on fsts_pkg, fsts_controller and fsts_datapath
//
// Usage:
//   req channel: one transaction carries an elapsed time in 2^-TimeFracBits s.
//   rsp channel: per enabled input, zero to MaxCatchup tick results
//     (tuser = 1, tlast = 0, rate 0) then one status result (tuser = 0,
//     tlast = 1) carrying the measured ticks per second in tdata.
//   csr port: index 0 step period (0 runs as 1), index 1 enable.
//     Write only while the block is idle.
//   The first result is presented in the cycle after the input is accepted.
//   One input at a time: an input with n ticks (0 to MaxCatchup) occupies the
//     block from its acceptance until its status result is taken, giving one
//     result per cycle on the rsp channel while the receiver does not stall.
//   A disabled block accepts inputs every cycle and emits nothing.
//   Reset: all accumulators, counters and the rate clear, step period returns
//     to 2185, scheduler disabled.
//   A stalled receiver holds the current result; req_tready stays low
//     until the status result has been taken.
module fixed_step_tick_scheduler
   import fsts_pkg::*;
#(
   parameter int MaxCatchup   = MAX_CATCHUP_DEF,
   parameter int TimeFracBits = TIME_FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // [19:0] elapsed, rest zero
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // [9:0] rate, rest zero
   output logic                   rsp_tuser,   // [0] is_tick
   output logic                   rsp_tlast,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [STEP_W-1:0]      csr_wdata
);

   cmd_type           cmd;
   sts_type           sts;
   logic [RATE_W-1:0] rate;

   fsts_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   fsts_datapath #(
      .MaxCatchup   (MaxCatchup),
      .TimeFracBits (TimeFracBits)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .elapsed   (req_tdata[ELAPSED_W-1:0]),
      .cmd       (cmd),
      .sts       (sts),
      .is_tick   (rsp_tuser),
      .last      (rsp_tlast),
      .rate      (rate)
   );

   assign rsp_tdata = RSP_DATA_W'(rate);

endmodule

/* rtl/fsts_datapath.sv */
// datapath: configuration registers, tick and window accumulators, rate meter
// depends on fsts_pkg and fixed_step_tick_scheduler_macros.svh
`include "fixed_step_tick_scheduler_macros.svh"
module fsts_datapath
   import fsts_pkg::*;
#(
   parameter int MaxCatchup   = MAX_CATCHUP_DEF,
   parameter int TimeFracBits = TIME_FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [STEP_W-1:0]      csr_wdata,
   input  logic [ELAPSED_W-1:0]   elapsed,
   input  cmd_type                cmd,
   output sts_type                sts,
   output logic                   is_tick,
   output logic                   last,
   output logic [RATE_W-1:0]      rate
);

   localparam int CatchW   = $clog2(MaxCatchup + 1);
   localparam int QuarterW = TimeFracBits - 1;
   localparam int CmpW     = (ELAPSED_W > QuarterW) ? ELAPSED_W : QuarterW;
   localparam logic [CmpW-1:0]     QuarterCmp = {{(CmpW-1){1'b0}}, 1'b1} << (TimeFracBits - 2);
   localparam logic [QuarterW-1:0] Quarter    = QuarterCmp[QuarterW-1:0];
   localparam logic [CatchW-1:0]   CatchMax   = CatchW'(MaxCatchup);

   logic [STEP_W-1:0]       step_ff, step_in;
   logic                    enable_ff, enable_in;
   logic [TICK_ACCUM_W-1:0] accum_ff, accum_in;
   logic [QuarterW-1:0]     window_ff, window_in;
   logic                    cross_ff, cross_in;
   logic [COUNT_W-1:0]      count_ff, count_in;
   logic [RATE_W-1:0]       rate_ff, rate_in;
   logic [CatchW-1:0]       catch_ff, catch_in;

   logic [CmpW-1:0]           dt_ext;
   logic [QuarterW-1:0]       dt;
   logic [TICK_ACCUM_W:0]     accum_sum;
   logic [TICK_ACCUM_W-1:0]   step_ext;
   logic [TICK_ACCUM_W-1:0]   accum_load;
   logic [TICK_ACCUM_W-1:0]   accum_left;
   logic [CatchW-1:0]         catch_next;
   logic [QuarterW-1:0]       window_sum;
   logic [RATE_W-1:0]         rate_new;

   assign dt_ext     = CmpW'(elapsed);
   assign dt         = (dt_ext > QuarterCmp) ? Quarter : dt_ext[QuarterW-1:0];
   assign accum_sum  = {1'b0, accum_ff} + (TICK_ACCUM_W+1)'(dt);
   // a zero period runs as one time unit
   assign step_ext   = (step_ff == '0) ? TICK_ACCUM_W'(1) : TICK_ACCUM_W'(step_ff);
   assign accum_load = accum_sum[TICK_ACCUM_W] ? '1 : accum_sum[TICK_ACCUM_W-1:0];
   assign accum_left = accum_ff - step_ext;
   assign catch_next = catch_ff + CatchW'(1);
   assign window_sum = window_ff + dt;
   assign rate_new   = {count_ff, 2'b00};

   always_comb begin
      step_in   = step_ff;
      enable_in = enable_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_STEP_PERIOD: step_in   = csr_wdata;
            CSR_ENABLE:      enable_in = csr_wdata[0];
            default:         ;
         endcase
      end
   end

   always_comb begin
      accum_in  = accum_ff;
      window_in = window_ff;
      cross_in  = cross_ff;
      count_in  = count_ff;
      rate_in   = rate_ff;
      catch_in  = catch_ff;
      if (cmd.load) begin
         accum_in  = accum_load;
         cross_in  = (window_sum >= Quarter);
         window_in = (window_sum >= Quarter) ? window_sum - Quarter : window_sum;
         catch_in  = '0;
      end
      if (cmd.tick_take) begin
         accum_in = accum_left;
         catch_in = catch_next;
         if (count_ff != '1) begin
            count_in = count_ff + COUNT_W'(1);
         end
      end
      // window close takes effect once the ticks of this transaction are counted
      if (cmd.status_take && cross_ff) begin
         rate_in  = rate_new;
         count_in = '0;
         cross_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= STEP_RESET;
         enable_ff <= 1'b0;
         accum_ff  <= '0;
         window_ff <= '0;
         cross_ff  <= 1'b0;
         count_ff  <= '0;
         rate_ff   <= '0;
         catch_ff  <= '0;
      end else begin
         step_ff   <= step_in;
         enable_ff <= enable_in;
         accum_ff  <= accum_in;
         window_ff <= window_in;
         cross_ff  <= cross_in;
         count_ff  <= count_in;
         rate_ff   <= rate_in;
         catch_ff  <= catch_in;
      end
   end

   assign sts.enabled         = enable_ff;
   assign sts.tick_on_load    = (accum_load >= step_ext);
   assign sts.tick_after_take = (accum_left >= step_ext) && (catch_next < CatchMax);

   assign is_tick = cmd.show_tick;
   assign last    = !cmd.show_tick;
   assign rate    = cmd.show_tick ? '0 : (cross_ff ? rate_new : rate_ff);

   `FSTS_ASSERT(a_catch_bound, clock, reset, catch_ff <= CatchMax, "catch-up count beyond limit")
   `FSTS_ASSERT(a_window_bound, clock, reset, window_ff < Quarter, "window beyond a quarter second")
   `FSTS_ASSERT_IMPL(a_tick_covered, clock, reset, cmd.tick_take, accum_ff >= step_ext,
      "tick taken without a whole period accumulated")

endmodule

/* rtl/fsts_controller.sv */
// controller: sequences accept, tick results and the closing status result
// depends on fsts_pkg and fixed_step_tick_scheduler_macros.svh
`include "fixed_step_tick_scheduler_macros.svh"
module fsts_controller
   import fsts_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_TICK   = 3'b010,
      S_STATUS = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in        = state_ff;
      cmd.load        = 1'b0;
      cmd.tick_take   = 1'b0;
      cmd.status_take = 1'b0;
      cmd.show_tick   = 1'b0;
      req_tready      = 1'b0;
      rsp_tvalid      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            // a disabled block drops the transaction
            if (req_tvalid && sts.enabled) begin
               cmd.load = 1'b1;
               state_in = sts.tick_on_load ? S_TICK : S_STATUS;
            end
         end
         S_TICK: begin
            rsp_tvalid    = 1'b1;
            cmd.show_tick = 1'b1;
            if (rsp_tready) begin
               cmd.tick_take = 1'b1;
               state_in      = sts.tick_after_take ? S_TICK : S_STATUS;
            end
         end
         S_STATUS: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               cmd.status_take = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `FSTS_ASSERT_IMPL(a_no_overlap, clock, reset, rsp_tvalid, !req_tready,
      "input taken while a result is pending")
   `FSTS_ASSERT_NEXT(a_status_ends, clock, reset, cmd.status_take, state_ff == S_IDLE,
      "status result not followed by idle")
   `FSTS_ASSERT_NEXT(a_load_leaves_idle, clock, reset, cmd.load,
      (state_ff == S_TICK) || (state_ff == S_STATUS), "load did not start a result run")

endmodule

/* tb/sv/tb_fixed_step_tick_scheduler.sv */
// self-checking testbench for the fixed-step tick scheduler: a scoreboard class predicts
// every tick and status result from the accepted elapsed times; depends on fsts_pkg and
// the fixed_step_tick_scheduler top level only
module tb_fixed_step_tick_scheduler;
   import fsts_pkg::*;

   localparam int CLK_PERIOD  = 12;
   localparam int QUARTER_SEC = 1 << (TIME_FRAC_BITS_DEF - 2);
   localparam int WINDOW_W    = TIME_FRAC_BITS_DEF - 1;

   typedef struct packed {
      logic              is_tick;
      logic              is_last;
      logic [RATE_W-1:0] rate;
   } sched_result_type;

   class tick_scoreboard;
      logic [STEP_W-1:0]       step_period;
      logic                    enabled;
      logic [TICK_ACCUM_W-1:0] tick_accum;
      logic [WINDOW_W-1:0]     window_accum;
      logic [COUNT_W-1:0]      tick_count;
      logic [RATE_W-1:0]       rate_reg;
      sched_result_type        due_q[$];
      int                      errors;
      int                      inputs_taken;
      int                      ticks_seen;
      int                      status_seen;

      function new();
         step_period  = STEP_RESET;
         enabled      = 1'b0;
         tick_accum   = '0;
         window_accum = '0;
         tick_count   = '0;
         rate_reg     = '0;
         errors       = 0;
         inputs_taken = 0;
         ticks_seen   = 0;
         status_seen  = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] index, logic [STEP_W-1:0] value);
         if (index == CSR_STEP_PERIOD) begin
            step_period = value;
         end else if (index == CSR_ENABLE) begin
            enabled = value[0];
         end
      endfunction

      // one accepted elapsed time: queue the ticks it pays for, then the status result
      function void note_elapsed(logic [ELAPSED_W-1:0] elapsed);
         logic [ELAPSED_W-1:0]  dt;
         logic [STEP_W-1:0]     step;
         logic [TICK_ACCUM_W:0] sum;
         int                    n;
         if (!enabled) return;
         inputs_taken++;
         dt   = (elapsed > QUARTER_SEC) ? ELAPSED_W'(QUARTER_SEC) : elapsed;
         step = (step_period == '0) ? STEP_W'(1) : step_period;
         sum  = tick_accum + dt;
         tick_accum   = sum[TICK_ACCUM_W] ? '1 : sum[TICK_ACCUM_W-1:0];
         window_accum = window_accum + dt[WINDOW_W-1:0];
         n = 0;
         while (tick_accum >= step && n < MAX_CATCHUP_DEF) begin
            tick_accum = tick_accum - step;
            if (tick_count != '1) tick_count++;
            due_q.push_back(sched_result_type'{is_tick: 1'b1, is_last: 1'b0, rate: '0});
            n++;
         end
         if (window_accum >= QUARTER_SEC) begin
            window_accum = window_accum - WINDOW_W'(QUARTER_SEC);
            rate_reg     = {tick_count, 2'b00};
            tick_count   = '0;
         end
         due_q.push_back(sched_result_type'{is_tick: 1'b0, is_last: 1'b1, rate: rate_reg});
      endfunction

      function void note_error(string msg);
         errors++;
         if (errors <= 10) $display("%s", msg);
      endfunction

      function void check_result(logic is_tick, logic is_last, logic [RSP_DATA_W-1:0] data);
         sched_result_type want;
         if (due_q.size() == 0) begin
            note_error($sformatf("result with nothing outstanding: tuser %0b tlast %0b tdata %0h",
                                 is_tick, is_last, data));
            return;
         end
         want = due_q.pop_front();
         if (is_tick) ticks_seen++;
         else status_seen++;
         if (is_tick !== want.is_tick || is_last !== want.is_last ||
             data !== RSP_DATA_W'(want.rate)) begin
            note_error($sformatf({"result check failed: expected tuser %0b tlast %0b rate %0d, ",
                                  "got tuser %0b tlast %0b tdata %0h"},
                                 want.is_tick, want.is_last, want.rate, is_tick, is_last, data));
         end
      endfunction

      function int pending();
         return due_q.size();
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;   // [19:0] elapsed, rest zero
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;   // [9:0] rate, rest zero
   logic                   rsp_tuser;   // [0] is_tick
   logic                   rsp_tlast;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [STEP_W-1:0]      csr_wdata;

   bit             steady_flow = 1'b0;
   int             rx_hold_len = 0;
   tick_scoreboard sb = new();

   fixed_step_tick_scheduler u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(CLK_PERIOD * 600000);
      $display("Mismatches found");
      $finish;
   end

   // receiver: random back-pressure, or a long hold-off when asked for
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (rx_hold_len > 0) begin
            rsp_tready <= 1'b0;
            repeat (rx_hold_len) @(posedge clock);
            rx_hold_len = 0;
         end else begin
            rsp_tready <= steady_flow || ($urandom_range(99) >= 28);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_elapsed(req_tdata[ELAPSED_W-1:0]);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tuser, rsp_tlast, rsp_tdata);
      end
   end

   task automatic send_elapsed(input logic [ELAPSED_W-1:0] elapsed);
      if (!steady_flow && $urandom_range(99) < 28) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'(elapsed);
      do @(posedge clock); while (!req_tready);
   endtask

   // drop valid and wait until every outstanding result has been taken
   task automatic settle(input int extra);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index, input logic [STEP_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.write_reg(index, value);
      @(posedge clock);
   endtask

   function automatic logic [ELAPSED_W-1:0] pick_elapsed(input int unsigned step);
      int unsigned roll;
      int unsigned span;
      roll = $urandom_range(99);
      span = (step == 0) ? 4 : step * 4;
      if (roll < 40) return ELAPSED_W'($urandom_range(0, span));
      if (roll < 70) return ELAPSED_W'($urandom());
      if (roll < 90) return ELAPSED_W'($urandom_range(QUARTER_SEC - 400, QUARTER_SEC + 400));
      if (roll < 95) return '0;
      return '1;
   endfunction

   initial begin
      int unsigned step_choice;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // disabled out of reset: inputs are swallowed
      send_elapsed(20'h00000);
      send_elapsed(20'hFFFFF);
      send_elapsed(20'h04000);
      settle(16);

      write_csr(CSR_ENABLE, STEP_W'(1));
      send_elapsed(20'h00000);
      send_elapsed(20'h00001);
      send_elapsed(20'h00888);
      send_elapsed(20'h00889);
      send_elapsed(20'h03FFF);
      send_elapsed(20'h04000);
      send_elapsed(20'h04001);
      send_elapsed(20'hFFFFF);
      send_elapsed(20'hAAAAA);
      send_elapsed(20'h55555);
      send_elapsed(20'h80000);
      settle(4);

      // zero period runs as one unit; catch-up limit leaves time over
      write_csr(CSR_STEP_PERIOD, '0);
      send_elapsed(20'hFFFFF);
      send_elapsed(20'h00000);
      send_elapsed(20'h00003);
      settle(4);

      write_csr(CSR_STEP_PERIOD, STEP_W'(65536));
      repeat (4) send_elapsed(20'h04000);
      send_elapsed(20'h0FFFF);

      for (int s = 0; s < 6; s++) begin
         settle(16);
         case (s)
            0: step_choice = 1;
            1: step_choice = 65536;
            2: step_choice = 0;
            3: step_choice = $urandom_range(1, 4096);
            4: step_choice = $urandom_range(1, 65536);
            default: step_choice = 2185;
         endcase
         write_csr(CSR_STEP_PERIOD, STEP_W'(step_choice));
         if (s == 4) begin
            write_csr(CSR_ENABLE, '0);
            repeat (4) send_elapsed(pick_elapsed(step_choice));
            settle(16);
            write_csr(CSR_ENABLE, STEP_W'(1));
         end
         if (s == 1) steady_flow = 1'b1;
         // receiver stalls for a long stretch so the input side backs up
         if (s == 2) rx_hold_len = 300;
         for (int k = 0; k < 10; k++) begin
            if (s == 3 && k == 5) settle(0);
            send_elapsed(pick_elapsed(step_choice));
         end
         steady_flow = 1'b0;
      end

      // unit period with frames of about 600 units: ten ticks per frame and at least
      // 26 frames per window, so the tick count saturates before the window closes
      settle(16);
      write_csr(CSR_STEP_PERIOD, STEP_W'(1));
      steady_flow = 1'b1;
      repeat (60) send_elapsed(ELAPSED_W'($urandom_range(580, 620)));
      steady_flow = 1'b0;
      settle(4);
      write_csr(CSR_STEP_PERIOD, STEP_W'(65536));
      repeat (6) send_elapsed(pick_elapsed(65536));
      settle(16);
      write_csr(CSR_ENABLE, '0);
      repeat (4) send_elapsed(pick_elapsed(2185));
      settle(20);

      $display("covered %0d enabled elapsed-time transactions giving %0d tick and %0d status results",
               sb.inputs_taken, sb.ticks_seen, sb.status_seen);
      $display("periods 0, 1, 2185, 65536 and random, enable toggled, tick count saturated");
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
